// File: rtl/fra_pkg.sv
// Shared types, field widths and codes for the frame ring allocator.
// No dependencies; every other file of the block but fra_ram imports this package.
package fra_pkg;

   localparam int FUNC_W         = 2;
   localparam int LEN_W          = 16;
   localparam int STATUS_W       = 3;
   localparam int OFS_W          = 12;
   localparam int HELD_W         = 13;
   localparam int BYTE_W         = 8;
   localparam int HDR_BYTES      = 2;
   localparam int RING_BYTES_DEF = 4096;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESERVE = 2'd0,
      FUNC_COMMIT  = 2'd1,
      FUNC_RELEASE = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 3'd0,
      STATUS_FULL  = 3'd1,
      STATUS_BAD   = 3'd2,
      STATUS_EMPTY = 3'd3,
      STATUS_NORES = 3'd4
   } status_type;

   typedef struct packed {
      status_type              status;
      logic [OFS_W-1:0]        payload_offset;
      logic [LEN_W-1:0]        out_len;
      logic [HELD_W-1:0]       frames_held;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } result_type;

endpackage

// File: rtl/fra_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module fra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4097
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/fra_ctrl.sv
// Sequencer of the frame ring allocator: head/tail pointers, frame count,
// header reads and writes through the byte RAM. Depends on fra_pkg.
module fra_ctrl #(
   parameter int RING_BYTES = fra_pkg::RING_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [fra_pkg::FUNC_W-1:0]           func,
   input  logic [fra_pkg::LEN_W-1:0]            frame_len,
   input  logic                                 slot_free,
   output logic                                 idle,
   output fra_pkg::result_type                  result,
   output logic                                 mem_we,
   output logic [$clog2(RING_BYTES+1)-1:0]      mem_addr,
   output logic [fra_pkg::BYTE_W-1:0]           mem_wdata,
   input  logic [fra_pkg::BYTE_W-1:0]           mem_rdata
);
   import fra_pkg::*;

   localparam int POS_W  = $clog2(RING_BYTES + 1);
   localparam int CALC_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_WM0, S_WM1, S_WH0, S_WH1, S_RA, S_RB, S_RC, S_DONE
   } state_type;

   state_type          state_ff;
   func_type           op_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   rlen_ff;
   logic [POS_W-1:0]   head_ff;
   logic [POS_W-1:0]   tail_ff;
   logic [POS_W-1:0]   total_ff;
   logic               open_ff;
   logic               pass_ff;
   logic [BYTE_W-1:0]  lo_ff;
   rsp_word_type       res_ff;

   logic [CALC_W-1:0]  ring_c, head_c, tail_c, need_c, hdr_c;
   logic               bad_size, ring_full, head_below, fit_below, fit_end;
   logic [LEN_W-1:0]   rd_word;
   logic [POS_W-1:0]   pos_sel;

   always_comb begin
      hdr_c      = CALC_W'(HDR_BYTES);
      ring_c     = CALC_W'(RING_BYTES);
      head_c     = CALC_W'(head_ff);
      tail_c     = CALC_W'(tail_ff);
      need_c     = CALC_W'(len_ff) + hdr_c;
      bad_size   = (len_ff == '0) || (need_c >= ring_c);
      ring_full  = (tail_ff == head_ff) && (total_ff != '0);
      head_below = head_ff < tail_ff;
      fit_below  = (tail_c - head_c) > need_c;
      fit_end    = (head_c < ring_c) && ((ring_c - head_c) > need_c);
      rd_word    = {mem_rdata, lo_ff};
   end

   // RAM port: writes at the head, reads at the tail
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = '0;
      pos_sel   = head_ff;
      mem_addr  = head_ff;
      unique case (state_ff)
         S_WM0: begin
            mem_we = 1'b1;
         end
         S_WM1: begin
            mem_we   = 1'b1;
            mem_addr = head_ff + POS_W'(1);
         end
         S_WH0: begin
            mem_we    = 1'b1;
            mem_wdata = len_ff[BYTE_W-1:0];
         end
         S_WH1: begin
            mem_we    = 1'b1;
            mem_wdata = len_ff[LEN_W-1:BYTE_W];
            mem_addr  = head_ff + POS_W'(1);
         end
         S_RA: begin
            pos_sel  = tail_ff;
            mem_addr = tail_ff;
         end
         S_RB: begin
            pos_sel  = tail_ff;
            mem_addr = tail_ff + POS_W'(1);
         end
         default: begin
            pos_sel = head_ff;
         end
      endcase
   end

   assign idle         = (state_ff == S_IDLE);
   assign result.valid = (state_ff == S_DONE);
   assign result.word  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         total_ff <= '0;
         open_ff  <= 1'b0;
         pass_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= func_type'(func);
                  len_ff   <= frame_len;
                  pass_ff  <= 1'b0;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_ff.status         <= STATUS_OK;
               res_ff.payload_offset <= '0;
               res_ff.out_len        <= '0;
               res_ff.frames_held    <= HELD_W'(total_ff);
               state_ff              <= S_DONE;
               unique case (op_ff)
                  FUNC_RESERVE: begin
                     if (bad_size) begin
                        res_ff.status <= STATUS_BAD;
                     end else begin
                        open_ff <= 1'b0;
                        priority if (ring_full) begin
                           res_ff.status <= STATUS_FULL;
                        end else if (head_below) begin
                           if (fit_below) state_ff <= S_WH0;
                           else res_ff.status <= STATUS_FULL;
                        end else if (fit_end) begin
                           state_ff <= S_WH0;
                        end else begin
                           state_ff <= S_WM0;
                        end
                     end
                  end
                  FUNC_COMMIT: begin
                     if (!open_ff) begin
                        res_ff.status <= STATUS_NORES;
                     end else begin
                        head_ff  <= POS_W'(head_c + CALC_W'(rlen_ff) + hdr_c);
                        total_ff <= total_ff + POS_W'(1);
                        open_ff  <= 1'b0;
                        res_ff.frames_held <= HELD_W'(total_ff + POS_W'(1));
                     end
                  end
                  FUNC_RELEASE: begin
                     if (total_ff == '0) begin
                        res_ff.status <= STATUS_EMPTY;
                     end else begin
                        state_ff <= S_RA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_WM0: begin
               state_ff <= S_WM1;
            end
            S_WM1: begin
               head_ff <= '0;
               if (pass_ff) begin
                  res_ff.status <= STATUS_FULL;
                  state_ff      <= S_DONE;
               end else begin
                  pass_ff  <= 1'b1;
                  state_ff <= S_EXEC;
               end
            end
            S_WH0: begin
               state_ff <= S_WH1;
            end
            S_WH1: begin
               open_ff               <= 1'b1;
               rlen_ff               <= len_ff;
               res_ff.payload_offset <= OFS_W'(CALC_W'(pos_sel) + hdr_c);
               state_ff              <= S_DONE;
            end
            S_RA: begin
               state_ff <= S_RB;
            end
            S_RB: begin
               lo_ff    <= mem_rdata;
               state_ff <= S_RC;
            end
            S_RC: begin
               if ((rd_word == '0) && !pass_ff) begin
                  // wrap marker: oldest frame starts at offset zero
                  tail_ff  <= '0;
                  pass_ff  <= 1'b1;
                  state_ff <= S_RA;
               end else begin
                  tail_ff  <= POS_W'(tail_c + CALC_W'(rd_word) + hdr_c);
                  total_ff <= total_ff - POS_W'(1);
                  res_ff.out_len        <= rd_word;
                  res_ff.payload_offset <= OFS_W'(tail_c + hdr_c);
                  res_ff.frames_held    <= HELD_W'(total_ff - POS_W'(1));
                  state_ff              <= S_DONE;
               end
            end
            S_DONE: begin
               if (slot_free) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/frame_ring_allocator_top.sv
// Top level of the frame ring allocator: sequencer, ring RAM, result register.
// Depends on fra_pkg, fra_ram and fra_ctrl.
//
// Usage:
//  - req channel carries one word per operation: req_func selects reserve,
//    commit or release; req_frame_len is the payload size for reserve.
//  - rsp channel returns exactly one word per request: status, payload
//    offset, length read from the released header, and frames held.
//  - A reserve that finds no room before the ring end writes a wrap marker
//    first and checks again from offset zero; a release that meets a wrap
//    marker follows it back to offset zero.
//  - Throughput is one operation at a time; the sequencer moves one header
//    byte per cycle through the single RAM port. Commit uses the length
//    kept from the open reserve and skips the RAM entirely.
//  - The ring RAM holds RING_BYTES bytes plus one guard byte; it needs no
//    clearing at reset because every byte is written before it is read.
//  - Reset (synchronous, active high) empties the ring: pointers, frame
//    count and the open reservation are cleared.
//  - A stalled receiver does not block the next request: the result word
//    waits in the output register while the next operation runs; only the
//    final handoff of that operation waits for the register to drain.
module frame_ring_allocator_top #(
   parameter int RING_BYTES = fra_pkg::RING_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fra_pkg::FUNC_W-1:0]    req_func,
   input  logic [fra_pkg::LEN_W-1:0]     req_frame_len,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fra_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fra_pkg::OFS_W-1:0]     rsp_payload_offset,
   output logic [fra_pkg::LEN_W-1:0]     rsp_out_len,
   output logic [fra_pkg::HELD_W-1:0]    rsp_frames_held
);
   import fra_pkg::*;

   localparam int POS_W = $clog2(RING_BYTES + 1);

   logic               idle;
   logic               slot_free;
   result_type         result;
   logic               mem_we;
   logic [POS_W-1:0]   mem_addr;
   logic [BYTE_W-1:0]  mem_wdata;
   logic [BYTE_W-1:0]  mem_rdata;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   assign req_ready = idle;
   // output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   fra_ctrl #(
      .RING_BYTES (RING_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && idle),
      .func      (req_func),
      .frame_len (req_frame_len),
      .slot_free (slot_free),
      .idle      (idle),
      .result    (result),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // ring bytes plus the guard byte for a marker at the last position
   fra_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES + 1)
   ) u_ring (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (result.valid && slot_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_word_ff  <= result.word;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_word_ff.status;
   assign rsp_payload_offset = rsp_word_ff.payload_offset;
   assign rsp_out_len        = rsp_word_ff.out_len;
   assign rsp_frames_held    = rsp_word_ff.frames_held;

endmodule

// File: rtl/fra_checker.sv
// Port-level checks for the frame ring allocator, bound to the top level.
// Depends on fra_pkg and frame_ring_allocator_top.
module fra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fra_pkg::STATUS_W-1:0]  rsp_status,
   input logic [fra_pkg::OFS_W-1:0]     rsp_payload_offset,
   input logic [fra_pkg::LEN_W-1:0]     rsp_out_len,
   input logic [fra_pkg::HELD_W-1:0]    rsp_frames_held
);
   import fra_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_payload_offset) && $stable(rsp_out_len)
         && $stable(rsp_frames_held))
      else $error("rsp word changed while stalled");

   // one operation at a time: accept is followed by a busy cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous operation busy");

   // errors carry no offset or length
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_payload_offset == '0) && (rsp_out_len == '0))
      else $error("error word with nonzero offset or length");

   // an empty ring reports no frames held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_frames_held == '0))
      else $error("empty status with frames held");

endmodule

bind frame_ring_allocator_top fra_checker u_fra_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_payload_offset (rsp_payload_offset),
   .rsp_out_len        (rsp_out_len),
   .rsp_frames_held    (rsp_frames_held)
);

// File: tb/frame_ring_allocator_top_test.sv
// Self-checking bench for frame_ring_allocator_top: reserve, commit and release words
// are checked against an in-bench ring model, with random idle on both channels.
// Depends on fra_pkg and the frame_ring_allocator_top RTL only.
module frame_ring_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fra_pkg::*;

   localparam int RING = RING_BYTES_DEF;
   // func code with no operation behind it; the block answers ok and changes nothing
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned PTR_MASK = 32'h1FFFF;
   localparam int unsigned OFS_MASK = 32'hFFF;
   localparam int unsigned HELD_MASK = 32'h1FFF;
   localparam int RANDOM_OPS = 1650;
   localparam int QUIET_LIMIT = 4000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [LEN_W-1:0]  frame_len;
   } ring_op_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [LEN_W-1:0] req_frame_len = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFS_W-1:0] rsp_payload_offset;
   logic [LEN_W-1:0] rsp_out_len;
   logic [HELD_W-1:0] rsp_frames_held;

   frame_ring_allocator_top #(
      .RING_BYTES(RING)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_frame_len      (req_frame_len),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_out_len        (rsp_out_len),
      .rsp_frames_held    (rsp_frames_held)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Ring model. Only headers and wrap markers land in the ring; payload
   // bytes are never written, so the store holds nothing else.
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] ring_mem [0:RING];  // last byte is the guard byte
   int unsigned head_at = 0;
   int unsigned tail_at = 0;
   int unsigned held_count = 0;
   bit resv_open = 1'b0;

   ring_op_type ops_pending[$];
   rsp_word_type expected_words[$];
   int ops_accepted = 0;
   int mismatch_count = 0;

   // little-endian header read; bytes past the guard read as zero
   function automatic int unsigned hdr_read(int unsigned at);
      int unsigned lo, hi;
      lo = 0;
      hi = 0;
      if (at <= RING) lo = 32'(ring_mem[at]);
      if (at + 1 <= RING) hi = 32'(ring_mem[at + 1]);
      return lo | (hi << 8);
   endfunction

   function automatic void hdr_write(int unsigned at, int unsigned v);
      if (at <= RING) ring_mem[at] = v[7:0];
      if (at + 1 <= RING) ring_mem[at + 1] = v[15:8];
   endfunction

   // applies one accepted word to the model and returns the response it owes
   function automatic rsp_word_type ring_apply(logic [FUNC_W-1:0] func,
                                               logic [LEN_W-1:0] len);
      rsp_word_type w;
      status_type st;
      int unsigned need, offs, olen;
      bit settled, fits;
      int pass;
      st = STATUS_OK;
      offs = 0;
      olen = 0;
      case (func)
         FUNC_RESERVE: begin
            need = len + HDR_BYTES;
            if (len == 0 || need >= RING) begin
               st = STATUS_BAD;  // open reservation survives a refused size
            end else begin
               resv_open = 1'b0;
               settled = 1'b0;
               fits = 1'b0;
               // second pass only after the head wrapped to 0
               for (pass = 0; pass < 2; pass++) begin
                  if (!settled) begin
                     if (tail_at == head_at && held_count != 0) begin
                        settled = 1'b1;
                     end else if (head_at < tail_at) begin
                        fits = (tail_at - head_at > need);
                        settled = 1'b1;
                     end else if (head_at < RING && RING - head_at > need) begin
                        fits = 1'b1;
                        settled = 1'b1;
                     end else begin
                        // wrap marker stays even if the recheck fails
                        hdr_write(head_at, 0);
                        head_at = 0;
                        if (pass == 1) settled = 1'b1;
                     end
                  end
               end
               if (fits) begin
                  hdr_write(head_at, len);
                  resv_open = 1'b1;
                  offs = head_at + HDR_BYTES;
               end else begin
                  st = STATUS_FULL;
               end
            end
         end
         FUNC_COMMIT: begin
            if (!resv_open) begin
               st = STATUS_NORES;
            end else begin
               head_at = (head_at + hdr_read(head_at) + HDR_BYTES) & PTR_MASK;
               held_count = (held_count + 1) & PTR_MASK;
               resv_open = 1'b0;
            end
         end
         FUNC_RELEASE: begin
            if (held_count == 0) begin
               st = STATUS_EMPTY;
            end else begin
               if (hdr_read(tail_at) == 0) tail_at = 0;  // follow wrap marker
               olen = hdr_read(tail_at);
               offs = tail_at + HDR_BYTES;
               tail_at = (tail_at + olen + HDR_BYTES) & PTR_MASK;
               held_count--;
            end
         end
         default: ;
      endcase
      w.status = st;
      w.payload_offset = OFS_W'(offs & OFS_MASK);
      w.out_len = olen[LEN_W-1:0];
      w.frames_held = HELD_W'(held_count & HELD_MASK);
      return w;
   endfunction

   function automatic void note_mismatch(string what, rsp_word_type exp_w,
                                         rsp_word_type got_w);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display({"%0t %s: exp st %0d ofs %0d len %0d held %0d",
                   " / got st %0d ofs %0d len %0d held %0d"},
                  $realtime, what, exp_w.status, exp_w.payload_offset, exp_w.out_len,
                  exp_w.frames_held, got_w.status, got_w.payload_offset, got_w.out_len,
                  got_w.frames_held);
   endfunction

   // idle draw per word; off-stretches give back-to-back traffic
   function automatic int unsigned idle_draw(bit on);
      return on ? $urandom_range(0, 15) : 0;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: pops the pending queue, holds valid until accepted,
   // and feeds each accepted word to the model.
   // ------------------------------------------------------------------
   int unsigned req_wait = 0;
   bit req_idle_on = 1'b1;

   always @(posedge clock) begin : req_side
      ring_op_type op;
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            expected_words.push_back(ring_apply(req_func, req_frame_len));
            ops_accepted++;
         end
         if (fire || !req_valid) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (ops_pending.size() != 0) begin
               op = ops_pending.pop_front();
               req_valid <= 1'b1;
               req_func <= op.func;
               req_frame_len <= op.frame_len;
               if ($urandom_range(0, 63) == 0) req_idle_on = !req_idle_on;
               req_wait = idle_draw(req_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: stalls ready at random, checks every accepted word
   // against the oldest expectation.
   // ------------------------------------------------------------------
   int unsigned rsp_hold = 0;
   bit rsp_idle_on = 1'b1;

   always @(posedge clock) begin : rsp_side
      rsp_word_type got_w, exp_w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_w.status = status_type'(rsp_status);
            got_w.payload_offset = rsp_payload_offset;
            got_w.out_len = rsp_out_len;
            got_w.frames_held = rsp_frames_held;
            if (expected_words.size() == 0) begin
               note_mismatch("unexpected word", '0, got_w);
            end else begin
               exp_w = expected_words.pop_front();
               if (got_w.status != exp_w.status ||
                   got_w.payload_offset != exp_w.payload_offset ||
                   got_w.out_len != exp_w.out_len ||
                   got_w.frames_held != exp_w.frames_held)
                  note_mismatch("mismatch", exp_w, got_w);
            end
            if ($urandom_range(0, 63) == 0) rsp_idle_on = !rsp_idle_on;
            rsp_hold = idle_draw(rsp_idle_on);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stuck handshake on either side ends the run
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic push_op(logic [FUNC_W-1:0] func, logic [LEN_W-1:0] len);
      ring_op_type op;
      op.func = func;
      op.frame_len = len;
      ops_pending.push_back(op);
   endtask

   task automatic push_frame(logic [LEN_W-1:0] len);
      push_op(FUNC_RESERVE, len);
      push_op(FUNC_COMMIT, LEN_W'($urandom));
   endtask

   // mostly short frames, a few that take most of the ring
   function automatic logic [LEN_W-1:0] pick_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return LEN_W'($urandom_range(1, 300));
      if (r < 92) return LEN_W'($urandom_range(301, 1500));
      return LEN_W'($urandom_range(1501, RING - HDR_BYTES - 1));
   endfunction

   initial begin : stimulus
      int directed_count, issued, segment, roll;
      bit filling;

      // directed: error codes, size limits, wrap at the guard byte
      push_op(FUNC_RELEASE, 16'hFFFF);               // release from empty ring
      push_op(FUNC_COMMIT, 16'h0000);                // commit with nothing open
      push_op(FUNC_UNUSED, 16'hFFFF);                // unused code
      push_op(FUNC_RESERVE, 16'd0);                  // zero size
      push_op(FUNC_RESERVE, 16'hFFFF);               // size far too large
      push_op(FUNC_RESERVE, LEN_W'(RING - HDR_BYTES));  // just too large
      push_frame(LEN_W'(RING - HDR_BYTES - 1));      // largest frame, head ends at last byte
      push_op(FUNC_RESERVE, 16'd1);                  // marker in guard position, then full
      push_op(FUNC_RELEASE, 16'h0000);
      push_op(FUNC_RESERVE, 16'd10);                 // empty ring, room measured to tail
      push_op(FUNC_RESERVE, 16'd20);                 // repeat replaces the open one
      push_op(FUNC_COMMIT, 16'h5A5A);
      push_op(FUNC_RELEASE, 16'hA5A5);               // follows the marker back to 0
      repeat (4) push_frame(16'd1300);               // last one wraps and finds no room
      repeat (3) push_op(FUNC_RELEASE, 16'h0000);
      directed_count = ops_pending.size();

      // random: fill and drain phases of well-formed frames with some noise
      issued = 0;
      segment = 0;
      filling = 1'b1;
      while (issued < RANDOM_OPS) begin
         if (segment == 0) begin
            segment = $urandom_range(40, 120);
            filling = 1'($urandom_range(0, 1));
         end
         segment--;
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            case ($urandom_range(0, 4))
               0: push_op(FUNC_COMMIT, LEN_W'($urandom));
               1: push_op(FUNC_RESERVE, pick_len());  // left open
               2: push_op(FUNC_UNUSED, LEN_W'($urandom));
               3: push_op(FUNC_RESERVE, ($urandom_range(0, 3) == 0) ? 16'd0 :
                          16'($urandom_range(RING - HDR_BYTES, 16'hFFFF)));
               default: begin
                  push_op(FUNC_RESERVE, pick_len());  // replaced by the next reserve
                  push_frame(pick_len());
               end
            endcase
         end else if (roll < (filling ? 70 : 40)) begin
            push_frame(pick_len());
         end else begin
            push_op(FUNC_RELEASE, LEN_W'($urandom));
         end
         issued = ops_pending.size() - directed_count;
      end
      directed_count = ops_pending.size();  // now the total word count

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (ops_accepted < directed_count || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
